@@ rtl/core/gbb_pkg.sv @@
`timescale 1ns / 1ps
// gbb_pkg: types, constants and helpers for the gray brighten box blur core
// no dependencies
package gbb_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 2048;
	localparam int unsigned MAX_HEIGHT_DEF = 2048;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned COORD_W = 11;
	localparam int unsigned DIM_W   = 12;
	localparam int unsigned CFG_W   = 12;
	localparam int unsigned SUM_W   = 12;

	localparam logic [DIM_W-1:0] FRAME_COLS_RST = 12'd2000;
	localparam logic [DIM_W-1:0] FRAME_ROWS_RST = 12'd1500;
	localparam logic [PIX_W-1:0] BRIGHTNESS_RST = 8'd30;

	// luma weights in unsigned 0.16, summing to 65536
	localparam logic [15:0] WEIGHT_R = 16'd19595;
	localparam logic [15:0] WEIGHT_G = 16'd38470;
	localparam logic [15:0] WEIGHT_B = 16'd7471;

	// ceil(2^16 / 9), exact for sums up to 9 * 255
	localparam logic [12:0] DIV9_RECIP = 13'd7282;

	typedef enum logic [1:0] {
		CFG_FRAME_COLS = 2'd0,
		CFG_FRAME_ROWS = 2'd1,
		CFG_BRIGHTNESS = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]   blurred_gray;
		logic [COORD_W-1:0] out_col;
		logic [COORD_W-1:0] out_row;
		logic               frame_last;
	} pix_out_t;

	// last valid position for a raw dimension clamped to 3..maxv
	function automatic int unsigned dim_last(input logic [DIM_W-1:0] raw,
		input int unsigned maxv);
		int unsigned v;
		v = int'(raw);
		if (v < 3)
			return 2;
		else if (v > maxv)
			return maxv - 1;
		else
			return v - 1;
	endfunction

endpackage

@@ rtl/core/gray_brighten_box_blur_core.sv @@
`timescale 1ns / 1ps
// gray_brighten_box_blur_core: rgb to luma, brightness offset, 3x3 box blur
// depends on gbb_pkg; holds the two line store memories
//
// Takes one RGB pixel per clock in raster order and emits the blurred value of
// interior pixel (x-1, y-1) when pixel (x, y) with x >= 2 and y >= 2 arrives;
// border pixels are never emitted. Sustained rate is one pixel per cycle.
// Three register stages (stage 1 with the registered line store read, the 3x3
// sum stage and the divide-by-9 output register) lie between acceptance and
// out_valid. A result waiting on out_ready holds the whole pipeline and drops
// in_ready. Writing the frame width or height restarts the frame at (0, 0);
// configure only while no transaction is in flight. Line store contents need
// no clearing.
module gray_brighten_box_blur_core
	import gbb_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  pix_in_t           in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pix_out_t          out_data
);

	localparam int unsigned XW  = $clog2(MAX_WIDTH);
	localparam int unsigned YW  = $clog2(MAX_HEIGHT);
	localparam int unsigned XCW = (XW > COORD_W) ? XW : COORD_W;
	localparam int unsigned YCW = (YW > COORD_W) ? YW : COORD_W;
	localparam logic [XW-1:0] W_LAST_RST = XW'(dim_last(FRAME_COLS_RST, MAX_WIDTH));
	localparam logic [YW-1:0] H_LAST_RST = YW'(dim_last(FRAME_ROWS_RST, MAX_HEIGHT));

	// configuration and position
	logic [XW-1:0]    w_last_q;
	logic [YW-1:0]    h_last_q;
	logic [PIX_W-1:0] bright_q;
	logic [XW-1:0]    col_count_q;
	logic [YW-1:0]    row_count_q;

	// line stores
	logic [PIX_W-1:0] older_mem [MAX_WIDTH];
	logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
	logic [PIX_W-1:0] win_q [6];

	// stage 1
	logic             vld_s1;
	logic             emit_s1;
	logic             last_s1;
	logic [XW-1:0]    x_s1;
	logic [YW-1:0]    y_s1;
	logic [PIX_W-1:0] gray_s1;
	logic [PIX_W-1:0] top_s1;
	logic [PIX_W-1:0] mid_s1;

	// stage 2
	logic               vld_s2;
	logic               last_s2;
	logic [SUM_W-1:0]   sum_s2;
	logic [COORD_W-1:0] col_s2;
	logic [COORD_W-1:0] row_s2;

	logic             en;
	logic             accept;
	logic [23:0]      luma_acc;
	logic [PIX_W:0]   bright_sum;
	logic [PIX_W-1:0] gray_in;
	logic [SUM_W-1:0] sum_s1;
	logic [XCW-1:0]   col_m1;
	logic [YCW-1:0]   row_m1;
	logic [23:0]      div_prod;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && en;

	assign luma_acc = 24'(in_data.red) * 24'(WEIGHT_R)
		+ 24'(in_data.green) * 24'(WEIGHT_G)
		+ 24'(in_data.blue) * 24'(WEIGHT_B);
	assign bright_sum = {1'b0, luma_acc[23:16]} + {1'b0, bright_q};
	assign gray_in    = bright_sum[PIX_W] ? '1 : bright_sum[PIX_W-1:0];

	assign sum_s1 = SUM_W'(gray_s1) + SUM_W'(top_s1) + SUM_W'(mid_s1)
		+ SUM_W'(win_q[0]) + SUM_W'(win_q[1]) + SUM_W'(win_q[2])
		+ SUM_W'(win_q[3]) + SUM_W'(win_q[4]) + SUM_W'(win_q[5]);
	assign col_m1 = XCW'(x_s1) - XCW'(1);
	assign row_m1 = YCW'(y_s1) - YCW'(1);

	// 9 * 255 * 7282 stays below 2^24
	assign div_prod = 24'(sum_s2) * 24'(DIV9_RECIP);

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q    <= W_LAST_RST;
			h_last_q    <= H_LAST_RST;
			bright_q    <= BRIGHTNESS_RST;
			col_count_q <= '0;
			row_count_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_FRAME_COLS: begin
					w_last_q    <= XW'(dim_last(cfg_wr_data[DIM_W-1:0], MAX_WIDTH));
					col_count_q <= '0;
					row_count_q <= '0;
				end
				CFG_FRAME_ROWS: begin
					h_last_q    <= YW'(dim_last(cfg_wr_data[DIM_W-1:0], MAX_HEIGHT));
					col_count_q <= '0;
					row_count_q <= '0;
				end
				CFG_BRIGHTNESS: begin
					bright_q <= cfg_wr_data[PIX_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (col_count_q == w_last_q) begin
				col_count_q <= '0;
				row_count_q <= (row_count_q == h_last_q) ? '0 : row_count_q + 1'b1;
			end else begin
				col_count_q <= col_count_q + 1'b1;
			end
		end
	end

	// line stores: read on acceptance, write when the item leaves stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			top_s1 <= older_mem[col_count_q];
			if (vld_s1)
				older_mem[x_s1] <= mid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s1 <= newer_mem[col_count_q];
			if (vld_s1)
				newer_mem[x_s1] <= gray_s1;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= col_count_q;
			y_s1    <= row_count_q;
			gray_s1 <= gray_in;
			emit_s1 <= (col_count_q >= XW'(2)) && (row_count_q >= YW'(2));
			last_s1 <= (col_count_q == w_last_q) && (row_count_q == h_last_q);
		end
	end

	// window of the two previous columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (en && vld_s1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= gray_s1;
		end
	end

	// stage 2: nine-value sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= sum_s1;
			col_s2  <= col_m1[COORD_W-1:0];
			row_s2  <= row_m1[COORD_W-1:0];
			last_s2 <= last_s1;
		end
	end

	// output register: divide by 9
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.blurred_gray <= div_prod[23:16];
			out_data.out_col      <= col_s2;
			out_data.out_row      <= row_s2;
			out_data.frame_last   <= last_s2;
		end
	end

	// position never runs past the configured frame
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_count_q <= w_last_q && row_count_q <= h_last_q)
		else $error("position counter beyond frame size");

	// an interior input transaction reaches stage 1 with its emit flag
	a_emit_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_wr_en && col_count_q >= XW'(2) && row_count_q >= YW'(2))
		|=> (vld_s1 && emit_s1))
		else $error("interior transaction lost before stage 2");

	// a summed result always lands in the output register
	a_s2_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s2) |=> out_valid)
		else $error("stage 2 result dropped");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking testbench for gray_brighten_box_blur_core (luma, brighten, 3x3 blur)
// depends on gbb_pkg and the core; predicts every blurred pixel and checks it in order

module tb
	import gbb_pkg::*;
();

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned PIPE_SETTLE = 8;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_ready;
	pix_in_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	pix_out_t out_data;

	gray_brighten_box_blur_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// predictor state
	logic [DIM_W-1:0] model_width = FRAME_COLS_RST;
	logic [DIM_W-1:0] model_height = FRAME_ROWS_RST;
	logic [PIX_W-1:0] model_bright = BRIGHTNESS_RST;
	bit [PIX_W-1:0] row_above2 [MAX_WIDTH_DEF];
	bit [PIX_W-1:0] row_above1 [MAX_WIDTH_DEF];
	bit [PIX_W-1:0] win [6];
	int unsigned pos_x = 0;
	int unsigned pos_y = 0;

	pix_out_t blur_expect_q[$];
	int unsigned pix_in_cnt = 0;
	int unsigned checked_cnt = 0;
	int unsigned frame_cnt = 0;
	int unsigned reg_wr_cnt = 0;
	int unsigned mismatch_cnt = 0;

	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw,
		input int unsigned maxv);
		if (raw < 3)
			return 3;
		if (raw > maxv)
			return maxv;
		return 32'(raw);
	endfunction

	function automatic void apply_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		unique case (idx)
			CFG_FRAME_COLS: begin
				model_width = val[DIM_W-1:0];
				pos_x = 0;
				pos_y = 0;
			end
			CFG_FRAME_ROWS: begin
				model_height = val[DIM_W-1:0];
				pos_x = 0;
				pos_y = 0;
			end
			CFG_BRIGHTNESS: begin
				model_bright = val[PIX_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void predict_pixel(input pix_in_t px);
		int unsigned w, h, luma, top, mid, sum;
		pix_out_t want;
		w = eff_dim(model_width, MAX_WIDTH_DEF);
		h = eff_dim(model_height, MAX_HEIGHT_DEF);
		luma = (32'(WEIGHT_R) * 32'(px.red) + 32'(WEIGHT_G) * 32'(px.green)
			+ 32'(WEIGHT_B) * 32'(px.blue)) >> 16;
		luma = luma + 32'(model_bright);
		if (luma > 255)
			luma = 255;
		top = 32'(row_above2[pos_x]);
		mid = 32'(row_above1[pos_x]);
		if (pos_x >= 2 && pos_y >= 2) begin
			sum = top + mid + luma;
			for (int i = 0; i < 6; i++)
				sum += 32'(win[i]);
			want.blurred_gray = PIX_W'(sum / 9);
			want.out_col = COORD_W'(pos_x - 1);
			want.out_row = COORD_W'(pos_y - 1);
			want.frame_last = (pos_x == w - 1 && pos_y == h - 1);
			blur_expect_q.push_back(want);
		end
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = PIX_W'(top);
		win[4] = PIX_W'(mid);
		win[5] = PIX_W'(luma);
		row_above2[pos_x] = PIX_W'(mid);
		row_above1[pos_x] = PIX_W'(luma);
		pos_x++;
		if (pos_x >= w) begin
			pos_x = 0;
			pos_y++;
			if (pos_y >= h)
				pos_y = 0;
		end
	endfunction

	function automatic void check_result(input pix_out_t got);
		pix_out_t want;
		if (blur_expect_q.size() == 0) begin
			$error("unexpected result col %0d row %0d", got.out_col, got.out_row);
			mismatch_cnt++;
			return;
		end
		want = blur_expect_q.pop_front();
		if (got.blurred_gray !== want.blurred_gray) begin
			$error("blurred_gray expected %0d got %0d", want.blurred_gray, got.blurred_gray);
			mismatch_cnt++;
		end
		if (got.out_col !== want.out_col) begin
			$error("out_col expected %0d got %0d", want.out_col, got.out_col);
			mismatch_cnt++;
		end
		if (got.out_row !== want.out_row) begin
			$error("out_row expected %0d got %0d", want.out_row, got.out_row);
			mismatch_cnt++;
		end
		if (got.frame_last !== want.frame_last) begin
			$error("frame_last expected %0d got %0d", want.frame_last, got.frame_last);
			mismatch_cnt++;
		end
		checked_cnt++;
		if (want.frame_last)
			frame_cnt++;
	endfunction

	// transaction monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				apply_reg(cfg_index, cfg_wr_data);
			if (out_valid && out_ready)
				check_result(out_data);
			if (in_valid && in_ready) begin
				predict_pixel(in_data);
				pix_in_cnt++;
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[gray_brighten_box_blur_core] ERROR");
		$finish;
	end

	function automatic pix_in_t rand_pixel();
		pix_in_t p;
		p = 24'($urandom_range(0, 24'hFFFFFF));
		if ($urandom_range(0, 7) == 0)
			p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 7) == 0)
			p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 7) == 0)
			p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return p;
	endfunction

	function automatic logic [CFG_W-1:0] rand_dim(input bit tall);
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return CFG_W'($urandom_range(0, 2));
		if (tall && r == 1)
			return CFG_W'($urandom_range(MAX_HEIGHT_DEF + 1, 4095));
		return tall ? CFG_W'($urandom_range(3, 8)) : CFG_W'($urandom_range(3, 24));
	endfunction

	function automatic logic [CFG_W-1:0] rand_bright();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return CFG_W'(255);
		return CFG_W'($urandom_range(0, 4095));
	endfunction

	task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		reg_wr_cnt++;
		@(negedge clk);
	endtask

	task automatic send_pixel(input pix_in_t px);
		int unsigned snap;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			in_data <= rand_pixel();
			do
				@(negedge clk);
			while ($urandom_range(0, 99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= px;
		snap = pix_in_cnt;
		do
			@(negedge clk);
		while (pix_in_cnt == snap);
	endtask

	// wait for every pending result, then let pixels without a result leave the pipe
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (blur_expect_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	task automatic test_directed_extremes();
		pix_in_t corners [9];
		corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFFFF, 24'h000000, 24'hFFFF00, 24'h00FFFF};
		set_idling(0, 0);
		write_reg(CFG_FRAME_COLS, 12'd3);
		write_reg(CFG_FRAME_ROWS, 12'd3);
		write_reg(CFG_BRIGHTNESS, 12'd0);
		foreach (corners[i])
			send_pixel(corners[i]);
		drain_and_settle();
		// saturation on every pixel, second frame after wrap
		write_reg(CFG_BRIGHTNESS, 12'd255);
		foreach (corners[i])
			send_pixel(corners[i]);
		drain_and_settle();
	endtask

	task automatic test_register_corners();
		set_idling(0, 66);
		write_reg(CFG_UNUSED, 12'hFFF);
		write_reg(CFG_FRAME_COLS, 12'd2);
		write_reg(CFG_FRAME_ROWS, 12'd0);
		write_reg(CFG_BRIGHTNESS, 12'hF55);
		write_reg(CFG_UNUSED, 12'h000);
		repeat (18) send_pixel(rand_pixel());
		drain_and_settle();
	endtask

	task automatic test_midframe_writes();
		set_idling(31, 31);
		write_reg(CFG_FRAME_COLS, 12'd5);
		write_reg(CFG_FRAME_ROWS, 12'd4);
		write_reg(CFG_BRIGHTNESS, 12'd10);
		repeat (13) send_pixel(rand_pixel());
		drain_and_settle();
		write_reg(CFG_BRIGHTNESS, 12'd200);
		repeat (4) send_pixel(rand_pixel());
		drain_and_settle();
		// same width again still restarts the frame
		write_reg(CFG_FRAME_COLS, 12'd5);
		repeat (27) send_pixel(rand_pixel());
		drain_and_settle();
		write_reg(CFG_FRAME_ROWS, 12'd4);
		repeat (20) send_pixel(rand_pixel());
		drain_and_settle();
	endtask

	task automatic test_widest_row();
		set_idling(0, 0);
		write_reg(CFG_FRAME_COLS, 12'hFFF);
		write_reg(CFG_FRAME_ROWS, 12'd3);
		write_reg(CFG_BRIGHTNESS, rand_bright());
		repeat (240) send_pixel(rand_pixel());
		drain_and_settle();
	endtask

	task automatic test_tallest_frame();
		set_idling(0, 0);
		write_reg(CFG_FRAME_COLS, 12'd0);
		write_reg(CFG_FRAME_ROWS, 12'd2048);
		write_reg(CFG_BRIGHTNESS, rand_bright());
		repeat (240) send_pixel(rand_pixel());
		drain_and_settle();
	endtask

	task automatic test_random_frames(input int unsigned tx_pct, input int unsigned rx_pct,
		input int unsigned target);
		int unsigned sent, pick, w, h, n;
		set_idling(tx_pct, rx_pct);
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 3);
			if (pick != 2)
				write_reg(CFG_FRAME_COLS, rand_dim(1'b0));
			if (pick <= 1)
				write_reg(CFG_FRAME_ROWS, rand_dim(1'b1));
			if (pick >= 2 || $urandom_range(0, 1))
				write_reg(CFG_BRIGHTNESS, rand_bright());
			w = eff_dim(model_width, MAX_WIDTH_DEF);
			h = eff_dim(model_height, MAX_HEIGHT_DEF);
			n = $urandom_range(w * 3, w * h * 2);
			if (n > 100)
				n = 100;
			repeat (n) send_pixel(rand_pixel());
			sent += n;
			drain_and_settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_FRAME_COLS;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_extremes();
		test_register_corners();
		test_midframe_writes();
		test_widest_row();
		test_tallest_frame();
		test_random_frames(0, 0, 150);
		test_random_frames(66, 0, 150);
		test_random_frames(0, 66, 150);
		test_random_frames(31, 31, 150);

		drain_and_settle();
		repeat (10) @(negedge clk);
		$display("%0d pixels streamed across %0d register writes and four idling mixes",
			pix_in_cnt, reg_wr_cnt);
		$display("%0d blurred pixels checked, %0d frame ends seen", checked_cnt, frame_cnt);
		if (mismatch_cnt == 0)
			$display("[gray_brighten_box_blur_core] OK");
		else
			$display("[gray_brighten_box_blur_core] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/gbb_pkg.sv
rtl/core/gray_brighten_box_blur_core.sv
dv/tb.sv
